[rtl/core/nlpp_pkg.sv]
// Shared types, constants and helper functions of the nearest lane point projection block.
// Used by nlpp_front, nlpp_back and the top level nearest_lane_point_projection.
package nlpp_pkg;

    // Lane length limit and the segment counter that follows from it.
    localparam int MAX_POINTS_PER_LANE = 1024;
    localparam int SEG_W               = $clog2(MAX_POINTS_PER_LANE);
    localparam int SEG_LIMIT           = MAX_POINTS_PER_LANE - 1;

    // Queue between the front and the back part.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Iteration counts of the shared units.
    localparam int DIV_STEPS    = 16;
    localparam int SQRT_STEPS   = 26;
    localparam int CORDIC_STEPS = 16;

    // Angle and fixed point constants.
    localparam int PI_Q16      = 205887;
    localparam int PI_Q13      = 25736;
    localparam int TWO_PI_Q13  = 51472;
    localparam int RATIO_ONE   = 65536;

    // Configuration port.
    localparam int CFG_DATA_W         = 32;
    localparam int CFG_ADDR_W         = 3;
    localparam int MAX_DIST_W         = 25;
    localparam int MAX_HEAD_W         = 15;
    localparam int MAX_DIST_RESET     = 512;
    localparam int MAX_HEAD_RESET     = 6434;
    localparam logic REG_MAX_DIST     = 1'b0;
    localparam logic REG_MAX_HEAD     = 1'b1;

    // One input beat.
    typedef struct packed {
        logic signed [23:0] query_x;
        logic signed [23:0] query_y;
        logic signed [23:0] vertex_x;
        logic signed [23:0] vertex_y;
        logic [5:0]         lane_index;
        logic               lane_closed;
        logic               first_of_lane;
        logic               last_of_lane;
        logic               last_of_set;
        logic               heading_check;
        logic signed [15:0] required_heading;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic               found;
        logic [5:0]         best_lane;
        logic [9:0]         best_segment;
        logic [16:0]        best_ratio;
        logic signed [23:0] proj_x;
        logic signed [23:0] proj_y;
        logic [31:0]        arc_position;
        logic signed [15:0] lane_heading;
        logic [24:0]        match_distance;
    } t_out_item;

    // What the front part decided for one vertex.
    typedef enum logic [1:0] {
        KIND_START,
        KIND_SEG,
        KIND_SKIP
    } t_kind;

    typedef struct packed {
        t_in_item         item;
        t_kind            kind;
        logic [SEG_W-1:0] seg_idx;
        logic             end_lane;
    } t_work;

    // Sequencer states of the back part.
    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_A,
        S_SQ_B,
        S_DOT_A,
        S_DOT_B,
        S_CHECK,
        S_DIV,
        S_PX,
        S_PY,
        S_RX,
        S_RY,
        S_DSQ,
        S_DSQRT,
        S_LSQRT,
        S_CMP,
        S_ARC,
        S_CORDIC,
        S_YAW,
        S_ACC,
        S_END,
        S_OUT
    } t_state;

    // Saturate to 24 bit signed.
    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        logic signed [23:0] res;
        if (v > 40'sd8388607) begin
            res = 24'sd8388607;
        end else if (v < -40'sd8388608) begin
            res = -24'sd8388608;
        end else begin
            res = 24'(v);
        end
        return res;
    endfunction

    // Arctangent of 2^-i in Q.16 radians.
    function automatic logic [16:0] atan_q16(input logic [3:0] i);
        logic [16:0] res;
        case (i)
            4'd0:    res = 17'd51472;
            4'd1:    res = 17'd30386;
            4'd2:    res = 17'd16055;
            4'd3:    res = 17'd8150;
            4'd4:    res = 17'd4091;
            4'd5:    res = 17'd2047;
            4'd6:    res = 17'd1024;
            4'd7:    res = 17'd512;
            4'd8:    res = 17'd256;
            4'd9:    res = 17'd128;
            4'd10:   res = 17'd64;
            4'd11:   res = 17'd32;
            4'd12:   res = 17'd16;
            4'd13:   res = 17'd8;
            4'd14:   res = 17'd4;
            4'd15:   res = 17'd2;
            default: res = 17'd0;
        endcase
        return res;
    endfunction

endpackage

[rtl/core/nlpp_front.sv]
// Front part: accepts vertex beats, classifies them by the lane marks and queues them.
// Depends on nlpp_pkg.
module nlpp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nlpp_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_work_valid,
    output nlpp_pkg::t_work   o_work,
    input  logic              i_work_pop
);

    logic                          r_open;
    logic [nlpp_pkg::SEG_W-1:0]    r_seg_cnt;
    nlpp_pkg::t_work               r_q [nlpp_pkg::Q_DEPTH];
    logic [nlpp_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [nlpp_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [nlpp_pkg::Q_CNT_W-1:0]  r_count;
    logic                          c_acc;
    logic                          c_pop;
    nlpp_pkg::t_work               c_work;

    assign o_full       = (r_count == nlpp_pkg::Q_CNT_W'(nlpp_pkg::Q_DEPTH));
    assign o_work_valid = (r_count != '0);
    assign o_work       = r_q[r_rd_ptr];
    assign c_acc        = i_push && !o_full;
    assign c_pop        = i_work_pop && o_work_valid;

    // Classify the incoming vertex against the lane currently open.
    always_comb begin
        c_work          = '0;
        c_work.item     = i_item;
        c_work.end_lane = i_item.last_of_lane || i_item.last_of_set;
        if (i_item.first_of_lane || !r_open) begin
            c_work.kind = nlpp_pkg::KIND_START;
        end else if (r_seg_cnt < nlpp_pkg::SEG_W'(nlpp_pkg::SEG_LIMIT)) begin
            c_work.kind    = nlpp_pkg::KIND_SEG;
            c_work.seg_idx = r_seg_cnt;
        end else begin
            c_work.kind = nlpp_pkg::KIND_SKIP;
        end
    end

    // Lane tracking and queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_seg_cnt <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
        end else begin
            if (c_acc) begin
                if (c_work.kind == nlpp_pkg::KIND_START) begin
                    r_seg_cnt <= '0;
                end else if (c_work.kind == nlpp_pkg::KIND_SEG) begin
                    r_seg_cnt <= r_seg_cnt + 1'b1;
                end
                r_open   <= !c_work.end_lane;
                r_wr_ptr <= (r_wr_ptr == nlpp_pkg::Q_PTR_W'(nlpp_pkg::Q_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (c_pop) begin
                r_rd_ptr <= (r_rd_ptr == nlpp_pkg::Q_PTR_W'(nlpp_pkg::Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (c_acc && !c_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!c_acc && c_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (c_acc) begin
            r_q[r_wr_ptr] <= c_work;
        end
    end

endmodule

[rtl/core/nlpp_back.sv]
// Back part: projects the query onto each segment with shared multiply, divide, square
// root and CORDIC units, keeps lane and overall bests and holds the result. Uses nlpp_pkg.
module nlpp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_work_valid,
    input  nlpp_pkg::t_work                     i_work,
    output logic                                o_work_pop,
    input  logic [nlpp_pkg::MAX_DIST_W-1:0]     i_max_dist,
    input  logic [nlpp_pkg::MAX_HEAD_W-1:0]     i_max_head,
    output logic                                o_empty,
    output nlpp_pkg::t_out_item                 o_result,
    input  logic                                i_pop
);

    nlpp_pkg::t_state    r_state;
    nlpp_pkg::t_state    n_state;
    nlpp_pkg::t_work     r_w;
    logic signed [23:0]  r_prev_x;
    logic signed [23:0]  r_prev_y;
    logic signed [24:0]  r_dx;
    logic signed [24:0]  r_dy;
    logic signed [24:0]  r_ex;
    logic signed [24:0]  r_ey;
    logic signed [53:0]  r_prod;
    logic signed [53:0]  r_acc;
    logic [49:0]         r_sq;
    logic [50:0]         r_rem;
    logic [16:0]         r_ratio;
    logic [4:0]          r_cnt;
    logic signed [23:0]  r_px;
    logic signed [23:0]  r_py;
    logic [51:0]         r_sr_rem;
    logic [51:0]         r_root;
    logic [51:0]         r_bit;
    logic [24:0]         r_dist;
    logic [25:0]         r_len;
    logic [31:0]         r_arc_before;
    logic                r_lane_valid;
    logic [nlpp_pkg::SEG_W-1:0] r_lane_seg;
    logic [16:0]         r_lane_ratio;
    logic signed [23:0]  r_lane_px;
    logic signed [23:0]  r_lane_py;
    logic [31:0]         r_lane_arc;
    logic signed [15:0]  r_lane_yaw;
    logic [24:0]         r_lane_dist;
    logic signed [43:0]  r_cx;
    logic signed [43:0]  r_cy;
    logic signed [20:0]  r_cz;
    logic                r_ov_valid;
    nlpp_pkg::t_out_item r_ov;
    nlpp_pkg::t_out_item r_res;
    logic                r_res_valid;

    logic signed [26:0]  mul_a;
    logic signed [26:0]  mul_b;
    logic signed [53:0]  c_prod;
    logic signed [53:0]  c_dot;
    logic signed [53:0]  c_sq_s;
    logic [50:0]         c_rem2;
    logic                c_div_ge;
    logic signed [39:0]  c_rnd;
    logic signed [39:0]  c_pos;
    logic signed [26:0]  c_rx;
    logic signed [26:0]  c_ry;
    logic [51:0]         c_rb;
    logic                c_sqrt_ge;
    logic [51:0]         c_root_nxt;
    logic [27:0]         c_arc_inc;
    logic [32:0]         c_arc;
    logic [32:0]         c_arc_acc;
    logic signed [43:0]  c_x0;
    logic signed [43:0]  c_y0;
    logic signed [43:0]  c_xs;
    logic signed [43:0]  c_ys;
    logic signed [20:0]  c_atan;
    logic signed [20:0]  c_q;
    logic signed [15:0]  c_yaw;
    logic signed [17:0]  c_diff;
    logic signed [17:0]  c_wrap;
    logic [16:0]         c_abs;
    logic                c_lane_ok;
    logic                c_better;
    logic                c_last_step;
    logic                c_take;

    assign o_empty  = !r_res_valid;
    assign o_result = r_res;

    // Shared multiplier with a registered product.
    assign c_prod = mul_a * mul_b;

    // Dot product and squared length of the segment.
    assign c_dot  = r_acc + r_prod;
    assign c_sq_s = signed'(54'(r_sq));

    // Restoring divide step.
    assign c_rem2   = {r_rem[49:0], 1'b0};
    assign c_div_ge = (c_rem2 >= 51'(r_sq));

    // Rounded projection offset from the product.
    assign c_rnd = 40'((r_prod + 54'sd32768) >>> 16);
    assign c_pos = (r_state == nlpp_pkg::S_PY) ? 40'(r_prev_x) + c_rnd
                                                : 40'(r_prev_y) + c_rnd;

    // Query minus projected point.
    assign c_rx = 27'($signed(r_w.item.query_x)) - 27'(r_px);
    assign c_ry = 27'($signed(r_w.item.query_y)) - 27'(r_py);

    // Square root step, one result bit per cycle.
    assign c_rb       = r_root + r_bit;
    assign c_sqrt_ge  = (r_sr_rem >= c_rb);
    assign c_root_nxt = c_sqrt_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
    assign c_last_step = (r_cnt == 5'(nlpp_pkg::SQRT_STEPS - 1));

    // Arc position of the projection and the running lane length.
    assign c_arc_inc = 28'((r_prod + 54'sd32768) >>> 16);
    assign c_arc     = 33'(r_arc_before) + 33'(c_arc_inc);
    assign c_arc_acc = 33'(r_arc_before) + 33'(r_len);

    // CORDIC start, shifts and final heading.
    assign c_x0   = 44'(r_dx) <<< 16;
    assign c_y0   = 44'(r_dy) <<< 16;
    assign c_xs   = r_cx >>> r_cnt[3:0];
    assign c_ys   = r_cy >>> r_cnt[3:0];
    assign c_atan = 21'(nlpp_pkg::atan_q16(r_cnt[3:0]));
    assign c_q    = (r_cz + 21'sd4) >>> 3;
    always_comb begin
        if (c_q > 21'(nlpp_pkg::PI_Q13)) begin
            c_yaw = 16'(nlpp_pkg::PI_Q13);
        end else if (c_q < -21'(nlpp_pkg::PI_Q13)) begin
            c_yaw = -16'(nlpp_pkg::PI_Q13);
        end else begin
            c_yaw = 16'(c_q);
        end
    end

    // Lane acceptance at the lane end.
    assign c_diff = 18'($signed(r_w.item.required_heading)) - 18'(r_lane_yaw);
    always_comb begin
        if (c_diff > 18'(nlpp_pkg::PI_Q13)) begin
            c_wrap = c_diff - 18'(nlpp_pkg::TWO_PI_Q13);
        end else if (c_diff <= -18'(nlpp_pkg::PI_Q13)) begin
            c_wrap = c_diff + 18'(nlpp_pkg::TWO_PI_Q13);
        end else begin
            c_wrap = c_diff;
        end
        c_abs     = c_wrap[17] ? 17'(-c_wrap) : 17'(c_wrap);
        c_lane_ok = r_lane_valid && !r_w.item.lane_closed &&
                    (r_lane_dist <= i_max_dist) &&
                    !(r_w.item.heading_check && (c_abs > 17'(i_max_head)));
    end

    assign c_better = !r_lane_valid || (r_dist < r_lane_dist);
    assign c_take   = (r_state == nlpp_pkg::S_IDLE) && i_work_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            nlpp_pkg::S_IDLE: begin
                if (i_work_valid) begin
                    n_state = (i_work.kind == nlpp_pkg::KIND_SEG) ? nlpp_pkg::S_SQ_A
                                                                  : nlpp_pkg::S_END;
                end
            end
            nlpp_pkg::S_SQ_A:  n_state = nlpp_pkg::S_SQ_B;
            nlpp_pkg::S_SQ_B:  n_state = nlpp_pkg::S_DOT_A;
            nlpp_pkg::S_DOT_A: n_state = nlpp_pkg::S_DOT_B;
            nlpp_pkg::S_DOT_B: n_state = nlpp_pkg::S_CHECK;
            nlpp_pkg::S_CHECK: begin
                if (r_sq == '0) begin
                    n_state = nlpp_pkg::S_ACC;
                end else if (c_dot <= 54'sd0 || c_dot >= c_sq_s) begin
                    n_state = nlpp_pkg::S_PX;
                end else begin
                    n_state = nlpp_pkg::S_DIV;
                end
            end
            nlpp_pkg::S_DIV: begin
                if (r_cnt == 5'(nlpp_pkg::DIV_STEPS - 1)) begin
                    n_state = nlpp_pkg::S_PX;
                end
            end
            nlpp_pkg::S_PX:    n_state = nlpp_pkg::S_PY;
            nlpp_pkg::S_PY:    n_state = nlpp_pkg::S_RX;
            nlpp_pkg::S_RX:    n_state = nlpp_pkg::S_RY;
            nlpp_pkg::S_RY:    n_state = nlpp_pkg::S_DSQ;
            nlpp_pkg::S_DSQ:   n_state = nlpp_pkg::S_DSQRT;
            nlpp_pkg::S_DSQRT: begin
                if (c_last_step) begin
                    n_state = nlpp_pkg::S_LSQRT;
                end
            end
            nlpp_pkg::S_LSQRT: begin
                if (c_last_step) begin
                    n_state = nlpp_pkg::S_CMP;
                end
            end
            nlpp_pkg::S_CMP: n_state = c_better ? nlpp_pkg::S_ARC : nlpp_pkg::S_ACC;
            nlpp_pkg::S_ARC: n_state = nlpp_pkg::S_CORDIC;
            nlpp_pkg::S_CORDIC: begin
                if (r_cnt == 5'(nlpp_pkg::CORDIC_STEPS - 1)) begin
                    n_state = nlpp_pkg::S_YAW;
                end
            end
            nlpp_pkg::S_YAW: n_state = nlpp_pkg::S_ACC;
            nlpp_pkg::S_ACC: n_state = nlpp_pkg::S_END;
            nlpp_pkg::S_END: begin
                n_state = r_w.item.last_of_set ? nlpp_pkg::S_OUT : nlpp_pkg::S_IDLE;
            end
            nlpp_pkg::S_OUT: begin
                if (!r_res_valid) begin
                    n_state = nlpp_pkg::S_IDLE;
                end
            end
            default: n_state = nlpp_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: queue pop and multiplier operands.
    always_comb begin
        o_work_pop = c_take;
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            nlpp_pkg::S_SQ_A: begin
                mul_a = 27'(r_dx);
                mul_b = 27'(r_dx);
            end
            nlpp_pkg::S_SQ_B: begin
                mul_a = 27'(r_dy);
                mul_b = 27'(r_dy);
            end
            nlpp_pkg::S_DOT_A: begin
                mul_a = 27'(r_ex);
                mul_b = 27'(r_dx);
            end
            nlpp_pkg::S_DOT_B: begin
                mul_a = 27'(r_ey);
                mul_b = 27'(r_dy);
            end
            nlpp_pkg::S_PX: begin
                mul_a = 27'(signed'({1'b0, r_ratio}));
                mul_b = 27'(r_dx);
            end
            nlpp_pkg::S_PY: begin
                mul_a = 27'(signed'({1'b0, r_ratio}));
                mul_b = 27'(r_dy);
            end
            nlpp_pkg::S_RX: begin
                mul_a = c_rx;
                mul_b = c_rx;
            end
            nlpp_pkg::S_RY: begin
                mul_a = c_ry;
                mul_b = c_ry;
            end
            nlpp_pkg::S_CMP: begin
                mul_a = 27'(signed'({1'b0, r_ratio}));
                mul_b = 27'(signed'({1'b0, r_len}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control state: sequencer, lane and overall valid flags, lane tracking, result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nlpp_pkg::S_IDLE;
            r_lane_valid <= 1'b0;
            r_ov_valid   <= 1'b0;
            r_res_valid  <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_arc_before <= '0;
        end else begin
            r_state <= n_state;
            if (c_take && i_work.kind == nlpp_pkg::KIND_START) begin
                r_lane_valid <= 1'b0;
                r_arc_before <= '0;
                r_prev_x     <= i_work.item.vertex_x;
                r_prev_y     <= i_work.item.vertex_y;
            end
            if (r_state == nlpp_pkg::S_ARC) begin
                r_lane_valid <= 1'b1;
            end
            if (r_state == nlpp_pkg::S_ACC) begin
                r_arc_before <= c_arc_acc[32] ? '1 : c_arc_acc[31:0];
                r_prev_x     <= r_w.item.vertex_x;
                r_prev_y     <= r_w.item.vertex_y;
            end
            if (r_state == nlpp_pkg::S_END && r_w.end_lane) begin
                r_lane_valid <= 1'b0;
                if (c_lane_ok && (!r_ov_valid || r_lane_dist < r_ov.match_distance)) begin
                    r_ov_valid <= 1'b1;
                end
            end
            if (r_state == nlpp_pkg::S_OUT && !r_res_valid) begin
                r_res_valid <= 1'b1;
                r_ov_valid  <= 1'b0;
            end else if (i_pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= c_prod;
        case (r_state)
            nlpp_pkg::S_IDLE: begin
                if (i_work_valid) begin
                    r_w  <= i_work;
                    r_dx <= 25'($signed(i_work.item.vertex_x)) - 25'(r_prev_x);
                    r_dy <= 25'($signed(i_work.item.vertex_y)) - 25'(r_prev_y);
                    r_ex <= 25'($signed(i_work.item.query_x)) - 25'(r_prev_x);
                    r_ey <= 25'($signed(i_work.item.query_y)) - 25'(r_prev_y);
                end
            end
            nlpp_pkg::S_SQ_B: r_acc <= r_prod;
            nlpp_pkg::S_DOT_A: r_sq <= 50'(r_acc + r_prod);
            nlpp_pkg::S_DOT_B: r_acc <= r_prod;
            nlpp_pkg::S_CHECK: begin
                r_len <= '0;
                r_cnt <= '0;
                r_rem <= 51'(c_dot);
                if (c_dot <= 54'sd0) begin
                    r_ratio <= '0;
                end else if (c_dot >= c_sq_s) begin
                    r_ratio <= 17'(nlpp_pkg::RATIO_ONE);
                end else begin
                    r_ratio <= '0;
                end
            end
            nlpp_pkg::S_DIV: begin
                r_cnt   <= r_cnt + 1'b1;
                r_rem   <= c_div_ge ? c_rem2 - 51'(r_sq) : c_rem2;
                r_ratio <= {r_ratio[15:0], c_div_ge};
            end
            nlpp_pkg::S_PY: r_px <= nlpp_pkg::sat24(c_pos);
            nlpp_pkg::S_RX: r_py <= nlpp_pkg::sat24(c_pos);
            nlpp_pkg::S_RY: r_acc <= r_prod;
            nlpp_pkg::S_DSQ: begin
                r_sr_rem <= 52'(r_acc + r_prod);
                r_root   <= '0;
                r_bit    <= 52'(1) << 50;
                r_cnt    <= '0;
            end
            nlpp_pkg::S_DSQRT: begin
                if (c_last_step) begin
                    // Distance done; restart the unit on the squared segment length.
                    r_dist   <= (c_root_nxt > 52'(25'h1FFFFFF)) ? '1 : c_root_nxt[24:0];
                    r_sr_rem <= 52'(r_sq);
                    r_root   <= '0;
                    r_bit    <= 52'(1) << 50;
                    r_cnt    <= '0;
                end else begin
                    if (c_sqrt_ge) begin
                        r_sr_rem <= r_sr_rem - c_rb;
                    end
                    r_root <= c_root_nxt;
                    r_bit  <= r_bit >> 2;
                    r_cnt  <= r_cnt + 1'b1;
                end
            end
            nlpp_pkg::S_LSQRT: begin
                if (c_sqrt_ge) begin
                    r_sr_rem <= r_sr_rem - c_rb;
                end
                r_root <= c_root_nxt;
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt + 1'b1;
                if (c_last_step) begin
                    r_len <= c_root_nxt[25:0];
                end
            end
            nlpp_pkg::S_ARC: begin
                r_lane_seg   <= r_w.seg_idx;
                r_lane_ratio <= r_ratio;
                r_lane_px    <= r_px;
                r_lane_py    <= r_py;
                r_lane_dist  <= r_dist;
                r_lane_arc   <= c_arc[32] ? '1 : c_arc[31:0];
                r_cnt        <= '0;
                if (r_dx < 0) begin
                    r_cx <= -c_x0;
                    r_cy <= -c_y0;
                    r_cz <= (r_dy >= 0) ? 21'(nlpp_pkg::PI_Q16) : -21'(nlpp_pkg::PI_Q16);
                end else begin
                    r_cx <= c_x0;
                    r_cy <= c_y0;
                    r_cz <= '0;
                end
            end
            nlpp_pkg::S_CORDIC: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cy >= 0) begin
                    r_cx <= r_cx + c_ys;
                    r_cy <= r_cy - c_xs;
                    r_cz <= r_cz + c_atan;
                end else begin
                    r_cx <= r_cx - c_ys;
                    r_cy <= r_cy + c_xs;
                    r_cz <= r_cz - c_atan;
                end
            end
            nlpp_pkg::S_YAW: r_lane_yaw <= c_yaw;
            nlpp_pkg::S_END: begin
                if (r_w.end_lane && c_lane_ok &&
                    (!r_ov_valid || r_lane_dist < r_ov.match_distance)) begin
                    r_ov.found          <= 1'b1;
                    r_ov.best_lane      <= r_w.item.lane_index;
                    r_ov.best_segment   <= r_lane_seg;
                    r_ov.best_ratio     <= r_lane_ratio;
                    r_ov.proj_x         <= r_lane_px;
                    r_ov.proj_y         <= r_lane_py;
                    r_ov.arc_position   <= r_lane_arc;
                    r_ov.lane_heading   <= r_lane_yaw;
                    r_ov.match_distance <= r_lane_dist;
                end
            end
            nlpp_pkg::S_OUT: begin
                if (!r_res_valid) begin
                    r_res <= r_ov_valid ? r_ov : '0;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // A waiting result is neither lost nor changed until it is taken.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_pop) |=> (r_res_valid && $stable(r_res)))
        else $error("result beat changed before it was taken");

    // The divider remainder stays below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nlpp_pkg::S_DIV) |-> (r_rem < 51'(r_sq)))
        else $error("divider remainder out of range");

    // A result without a match carries zero fields.
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.found) |->
            (r_res.match_distance == '0 && r_res.best_lane == '0 &&
             r_res.arc_position == '0))
        else $error("no-match result carries nonzero fields");

    // A new result is loaded only into an empty slot.
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == nlpp_pkg::S_OUT && r_state == nlpp_pkg::S_IDLE) |->
            r_res_valid || $past(i_pop))
        else $error("result slot handling broken");
`endif

endmodule

[rtl/core/nearest_lane_point_projection.sv]
// Top level of the nearest lane point projection block: configuration registers and the
// front and back parts. Depends on nlpp_pkg, nlpp_front and nlpp_back.
//
// Vertex beats enter through a push/full queue port and are classified at once; a two-entry
// queue decouples that front from the back part, which works on one vertex at a time. A
// vertex that starts a lane or is past the lane length limit only passes the lane end step,
// and a zero-length segment skips the projection. For a regular segment the back shares one
// 27x27 multiplier and runs a 16-step restoring divider (only for a ratio strictly inside
// the segment), two 26-step square roots for distance and segment length, and, when the
// segment becomes the lane's new best, a 16-step CORDIC for the heading. The last vertex of
// a set loads the result, which then waits in its own slot while the next set is accepted.
// The configuration registers may be written only while the block is idle.
module nearest_lane_point_projection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  nlpp_pkg::t_in_item                  i_item,
    output logic                                empty,
    input  logic                                pop,
    output nlpp_pkg::t_out_item                 o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nlpp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [nlpp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [nlpp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [nlpp_pkg::MAX_DIST_W-1:0] r_max_dist;
    logic [nlpp_pkg::MAX_HEAD_W-1:0] r_max_head;
    logic                            c_wr;
    logic                            work_valid;
    nlpp_pkg::t_work                 work;
    logic                            work_pop;

    assign pready = 1'b1;
    assign c_wr   = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= nlpp_pkg::MAX_DIST_W'(nlpp_pkg::MAX_DIST_RESET);
            r_max_head <= nlpp_pkg::MAX_HEAD_W'(nlpp_pkg::MAX_HEAD_RESET);
        end else if (c_wr) begin
            case (paddr[2])
                nlpp_pkg::REG_MAX_DIST: r_max_dist <= pwdata[nlpp_pkg::MAX_DIST_W-1:0];
                nlpp_pkg::REG_MAX_HEAD: r_max_head <= pwdata[nlpp_pkg::MAX_HEAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr[2])
            nlpp_pkg::REG_MAX_DIST: prdata = nlpp_pkg::CFG_DATA_W'(r_max_dist);
            nlpp_pkg::REG_MAX_HEAD: prdata = nlpp_pkg::CFG_DATA_W'(r_max_head);
            default:                prdata = '0;
        endcase
    end

    // Front part: accept and classify.
    nlpp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_item),
        .o_full       (full),
        .o_work_valid (work_valid),
        .o_work       (work),
        .i_work_pop   (work_pop)
    );

    // Back part: projection, lane and overall best, result slot.
    nlpp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_work_pop   (work_pop),
        .i_max_dist   (r_max_dist),
        .i_max_head   (r_max_head),
        .o_empty      (empty),
        .o_result     (o_result),
        .i_pop        (pop)
    );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for nearest_lane_point_projection.
// Drives vertex beats and APB register writes, and checks each result against its own
// fixed-point predictor. Depends on nlpp_pkg and the RTL of the block.
module tb_top;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_ITEMS  = 40;
    localparam int DRAIN_WAIT  = 150;
    localparam logic [nlpp_pkg::CFG_ADDR_W-1:0] ADDR_MAX_DIST = {nlpp_pkg::REG_MAX_DIST, 2'b00};
    localparam logic [nlpp_pkg::CFG_ADDR_W-1:0] ADDR_MAX_HEAD = {nlpp_pkg::REG_MAX_HEAD, 2'b00};
    localparam longint COORD_MAX = 8388607;
    localparam longint COORD_MIN = -8388608;
    localparam longint DIST_CAP  = 33554431;
    localparam longint ARC_CAP   = 64'hFFFF_FFFF;
    localparam int ARCTAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    nlpp_pkg::t_in_item i_item;
    logic empty;
    logic pop;
    nlpp_pkg::t_out_item o_result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [nlpp_pkg::CFG_ADDR_W-1:0] paddr;
    logic [nlpp_pkg::CFG_DATA_W-1:0] pwdata;
    logic [nlpp_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    nearest_lane_point_projection uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock.
    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Predictor state: configuration, lane in progress and best match of the set.
    longint unsigned limit_dist;
    longint unsigned limit_head;
    longint prev_vx;
    longint prev_vy;
    int unsigned seg_cnt;
    longint unsigned arc_acc;
    bit lane_open;
    bit lane_has_best;
    nlpp_pkg::t_out_item lane_best;
    bit set_has_best;
    nlpp_pkg::t_out_item set_best;
    nlpp_pkg::t_out_item match_queue[$];

    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned rx_hold;
    longint unsigned cycle_count;

    // Fields of the next vertex beat.
    logic signed [23:0] cur_qx;
    logic signed [23:0] cur_qy;
    logic [5:0] cur_lane;
    logic cur_closed;
    logic cur_hchk;
    logic signed [15:0] cur_rhead;

    function automatic longint clamp24(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Segment heading by CORDIC vectoring, rounded to Q3.13 and clamped to +-pi.
    function automatic longint segment_heading(input longint dx, input longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint q;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? nlpp_pkg::PI_Q16 : -nlpp_pkg::PI_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q16[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q16[i];
            end
        end
        q = (z + 4) >>> 3;
        if (q > nlpp_pkg::PI_Q13) q = nlpp_pkg::PI_Q13;
        if (q < -nlpp_pkg::PI_Q13) q = -nlpp_pkg::PI_Q13;
        return q;
    endfunction

    // Project the query onto the segment from the previous vertex to (ex, ey).
    function automatic void project_segment(input longint qx, input longint qy,
                                            input longint ex, input longint ey);
        longint dx;
        longint dy;
        longint sq;
        longint dot;
        longint rem;
        longint ratio;
        longint px;
        longint py;
        longint rx;
        longint ry;
        longint unsigned seg_dist;
        longint unsigned len;
        longint unsigned arc;
        dx = ex - prev_vx;
        dy = ey - prev_vy;
        sq = dx * dx + dy * dy;
        if (sq == 0) return;
        dot = (qx - prev_vx) * dx + (qy - prev_vy) * dy;
        if (dot <= 0) begin
            ratio = 0;
        end else if (dot >= sq) begin
            ratio = nlpp_pkg::RATIO_ONE;
        end else begin
            rem = dot;
            ratio = 0;
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                ratio = ratio << 1;
                if (rem >= sq) begin
                    rem = rem - sq;
                    ratio = ratio | 1;
                end
            end
        end
        px = clamp24(prev_vx + ((ratio * dx + 32768) >>> 16));
        py = clamp24(prev_vy + ((ratio * dy + 32768) >>> 16));
        rx = qx - px;
        ry = qy - py;
        seg_dist = int_sqrt(rx * rx + ry * ry);
        if (seg_dist > DIST_CAP) seg_dist = DIST_CAP;
        len = int_sqrt(sq);
        if (!lane_has_best || seg_dist < lane_best.match_distance) begin
            arc = arc_acc + ((longint'(ratio) * len + 32768) >> 16);
            if (arc > ARC_CAP) arc = ARC_CAP;
            lane_has_best = 1'b1;
            lane_best.best_segment = seg_cnt[9:0];
            lane_best.best_ratio = 17'(ratio);
            lane_best.proj_x = 24'(px);
            lane_best.proj_y = 24'(py);
            lane_best.arc_position = 32'(arc);
            lane_best.lane_heading = 16'(segment_heading(dx, dy));
            lane_best.match_distance = 25'(seg_dist);
        end
        arc_acc = arc_acc + len;
        if (arc_acc > ARC_CAP) arc_acc = ARC_CAP;
    endfunction

    // Lane end: accept the lane's best against the limits and keep the earliest minimum.
    function automatic void close_lane(input nlpp_pkg::t_in_item it);
        bit ok;
        longint diff;
        ok = lane_has_best && !it.lane_closed;
        if (ok && lane_best.match_distance > limit_dist) ok = 1'b0;
        if (ok && it.heading_check) begin
            diff = longint'(it.required_heading) - longint'(lane_best.lane_heading);
            if (diff > nlpp_pkg::PI_Q13) diff = diff - nlpp_pkg::TWO_PI_Q13;
            else if (diff <= -nlpp_pkg::PI_Q13) diff = diff + nlpp_pkg::TWO_PI_Q13;
            if (diff < 0) diff = -diff;
            if (diff > longint'(limit_head)) ok = 1'b0;
        end
        if (ok && (!set_has_best || lane_best.match_distance < set_best.match_distance)) begin
            set_best = lane_best;
            set_best.best_lane = it.lane_index;
            set_best.found = 1'b1;
            set_has_best = 1'b1;
        end
        lane_open = 1'b0;
        lane_has_best = 1'b0;
    endfunction

    function automatic void predict_vertex(input nlpp_pkg::t_in_item it);
        nlpp_pkg::t_out_item res;
        if (it.first_of_lane || !lane_open) begin
            lane_open = 1'b1;
            lane_has_best = 1'b0;
            seg_cnt = 0;
            arc_acc = 0;
            prev_vx = it.vertex_x;
            prev_vy = it.vertex_y;
        end else if (seg_cnt < nlpp_pkg::SEG_LIMIT) begin
            project_segment(it.query_x, it.query_y, it.vertex_x, it.vertex_y);
            seg_cnt++;
            prev_vx = it.vertex_x;
            prev_vy = it.vertex_y;
        end
        if (it.last_of_lane || it.last_of_set) close_lane(it);
        if (it.last_of_set) begin
            res = '0;
            if (set_has_best) res = set_best;
            match_queue.insert(match_queue.size(), res);
            set_has_best = 1'b0;
            set_best = '0;
            lane_open = 1'b0;
            lane_has_best = 1'b0;
        end
    endfunction

    // Send one vertex beat after a random gap; called and returning at a falling edge.
    task automatic send_vertex(input nlpp_pkg::t_in_item it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_vertex(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic nlpp_pkg::t_in_item vtx(input longint vx, input longint vy,
                                               input bit first, input bit lastl,
                                               input bit lasts);
        nlpp_pkg::t_in_item it;
        it.query_x = cur_qx;
        it.query_y = cur_qy;
        it.vertex_x = 24'(clamp24(vx));
        it.vertex_y = 24'(clamp24(vy));
        it.lane_index = cur_lane;
        it.lane_closed = cur_closed;
        it.first_of_lane = first;
        it.last_of_lane = lastl;
        it.last_of_set = lasts;
        it.heading_check = cur_hchk;
        it.required_heading = cur_rhead;
        return it;
    endfunction

    task automatic lane_attrs(input int lane, input bit closed, input bit hchk,
                              input int rhead);
        cur_lane = 6'(lane);
        cur_closed = closed;
        cur_hchk = hchk;
        cur_rhead = 16'(rhead);
    endtask

    // Wait until every expected result has come and the back part has gone quiet.
    task automatic wait_drained();
        push <= 1'b0;
        while (match_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // APB write with setup and access phase, then a read back of the register.
    task automatic write_reg(input logic [nlpp_pkg::CFG_ADDR_W-1:0] addr,
                             input longint unsigned data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(data);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MAX_DIST) limit_dist = data & 64'h1FF_FFFF;
        else limit_head = data & 64'h7FFF;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != 32'((addr == ADDR_MAX_DIST) ? limit_dist : limit_head)) begin
            $display("%0t: register %0d read back expected %0d actual %0d", $time, addr,
                     (addr == ADDR_MAX_DIST) ? limit_dist : limit_head, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random set: mostly well-formed lanes near the query, some broken marks and noise.
    task automatic random_set();
        int n_lanes;
        int n_verts;
        int span;
        bit noise;
        longint vx;
        longint vy;
        bit first;
        bit lastl;
        bit lasts;
        noise = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 2))
            0: span = 300;
            1: span = 4000;
            default: span = 200000;
        endcase
        if (noise || $urandom_range(0, 7) == 0) begin
            cur_qx = 24'($urandom);
            cur_qy = 24'($urandom);
        end else begin
            cur_qx = 24'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            cur_qy = 24'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        end
        n_lanes = $urandom_range(1, 4);
        for (int l = 0; l < n_lanes; l++) begin
            lane_attrs($urandom_range(0, 63), $urandom_range(0, 6) == 0, $urandom_range(0, 1),
                       int'($urandom_range(0, nlpp_pkg::TWO_PI_Q13)) - nlpp_pkg::PI_Q13);
            n_verts = $urandom_range(1, 6);
            vx = cur_qx;
            vy = cur_qy;
            for (int k = 0; k < n_verts; k++) begin
                if (noise) begin
                    vx = longint'(signed'(24'($urandom)));
                    vy = longint'(signed'(24'($urandom)));
                end else if (k == 0 || $urandom_range(0, 6) != 0) begin
                    vx = longint'(cur_qx) + int'($urandom_range(0, 2 * span)) - span;
                    vy = longint'(cur_qy) + int'($urandom_range(0, 2 * span)) - span;
                end
                first = (k == 0) ^ ($urandom_range(0, 19) == 0);
                lastl = (k == n_verts - 1) ^ ($urandom_range(0, 19) == 0);
                lasts = (l == n_lanes - 1) && (k == n_verts - 1);
                if ($urandom_range(0, 5) == 0) cur_hchk = $urandom_range(0, 1);
                send_vertex(vtx(vx, vy, first, lastl, lasts));
            end
        end
    endtask

    // Result checker: compares each popped result with the oldest expectation.
    task automatic report_field(input string name, input longint unsigned e,
                                input longint unsigned a);
        if (e != a) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        nlpp_pkg::t_out_item exp_res;
        if (i_rst_n && pop && !empty) begin
            if (match_queue.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time,
                         o_result);
                fail_count++;
            end else begin
                exp_res = match_queue.pop_front();
                report_field("found", exp_res.found, o_result.found);
                report_field("best_lane", exp_res.best_lane, o_result.best_lane);
                report_field("best_segment", exp_res.best_segment, o_result.best_segment);
                report_field("best_ratio", exp_res.best_ratio, o_result.best_ratio);
                report_field("proj_x", exp_res.proj_x, o_result.proj_x);
                report_field("proj_y", exp_res.proj_y, o_result.proj_y);
                report_field("arc_position", exp_res.arc_position, o_result.arc_position);
                report_field("lane_heading", exp_res.lane_heading, o_result.lane_heading);
                report_field("match_distance", exp_res.match_distance,
                             o_result.match_distance);
            end
        end
    end

    // Result receiver with random stalls and an occasional long hold-off.
    initial begin
        int gap;
        pop = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                pop <= 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_reset_values();
        write_reg(ADDR_MAX_DIST, nlpp_pkg::MAX_DIST_RESET);
        write_reg(ADDR_MAX_HEAD, nlpp_pkg::MAX_HEAD_RESET);
    endtask

    // Directed sets: ratio inside, before and after the segment, zero length, single vertex,
    // closed lane, missing first mark, set end inside a lane, heading wrap, ties.
    task automatic test_directed();
        cur_qx = 0;
        cur_qy = 256;
        lane_attrs(0, 0, 0, 0);
        send_vertex(vtx(-512, 0, 1, 0, 0));
        send_vertex(vtx(512, 0, 0, 1, 1));
        cur_qx = -300;
        cur_qy = 0;
        lane_attrs(5, 0, 0, 0);
        send_vertex(vtx(0, 0, 1, 0, 0));
        send_vertex(vtx(0, 0, 0, 0, 0));
        send_vertex(vtx(100, 0, 0, 1, 0));
        lane_attrs(6, 0, 0, 0);
        send_vertex(vtx(-500, 10, 1, 0, 0));
        send_vertex(vtx(-400, 10, 0, 1, 1));
        cur_qx = 0;
        cur_qy = 0;
        lane_attrs(9, 0, 0, 0);
        send_vertex(vtx(5, 5, 1, 1, 0));
        lane_attrs(10, 1, 0, 0);
        send_vertex(vtx(-10, 0, 1, 0, 0));
        send_vertex(vtx(10, 0, 0, 1, 0));
        lane_attrs(11, 0, 0, 0);
        send_vertex(vtx(0, -50, 0, 0, 0));
        send_vertex(vtx(0, 50, 0, 0, 1));
        // Heading near pi against a required heading of -pi wraps to a small difference.
        cur_qx = 0;
        cur_qy = 20;
        lane_attrs(12, 0, 1, -nlpp_pkg::PI_Q13);
        send_vertex(vtx(100, 0, 1, 0, 0));
        send_vertex(vtx(-100, 0, 0, 1, 0));
        lane_attrs(13, 0, 1, 0);
        send_vertex(vtx(100, 1, 1, 0, 0));
        send_vertex(vtx(-100, 1, 0, 1, 1));
        // Two identical lanes: the earlier one fails its heading check, so the later one is kept.
        lane_attrs(20, 0, 1, nlpp_pkg::PI_Q13);
        send_vertex(vtx(0, -100, 1, 0, 0));
        send_vertex(vtx(0, 100, 0, 1, 0));
        lane_attrs(21, 0, 0, 0);
        send_vertex(vtx(0, -100, 1, 0, 0));
        send_vertex(vtx(0, 100, 0, 1, 1));
        wait_drained();
    endtask

    // Limits at their extremes, with far-apart coordinates at the edges of the range.
    task automatic test_limits();
        write_reg(ADDR_MAX_DIST, DIST_CAP);
        write_reg(ADDR_MAX_HEAD, nlpp_pkg::PI_Q13);
        cur_qx = 24'(COORD_MIN);
        cur_qy = 24'(COORD_MIN);
        lane_attrs(63, 0, 1, nlpp_pkg::PI_Q13);
        send_vertex(vtx(COORD_MAX, COORD_MAX, 1, 0, 0));
        send_vertex(vtx(COORD_MIN, COORD_MAX, 0, 0, 0));
        send_vertex(vtx(COORD_MAX, COORD_MIN, 0, 1, 1));
        cur_qx = 24'(COORD_MAX);
        cur_qy = 24'(COORD_MIN);
        lane_attrs(0, 0, 1, -nlpp_pkg::PI_Q13);
        send_vertex(vtx(COORD_MIN, COORD_MIN, 1, 0, 0));
        send_vertex(vtx(COORD_MIN, COORD_MAX, 0, 1, 1));
        wait_drained();
        write_reg(ADDR_MAX_DIST, 0);
        write_reg(ADDR_MAX_HEAD, 0);
        cur_qx = 0;
        cur_qy = 0;
        lane_attrs(1, 0, 1, 0);
        send_vertex(vtx(-100, 0, 1, 0, 0));
        send_vertex(vtx(100, 0, 0, 1, 1));
        wait_drained();
    endtask

    // A lane longer than the vertex limit: extra vertices form no segment.
    task automatic test_long_lane();
        longint vx;
        write_reg(ADDR_MAX_DIST, 1 << 20);
        cur_qx = 4200;
        cur_qy = 30;
        lane_attrs(33, 0, 0, 0);
        vx = 0;
        for (int k = 0; k < nlpp_pkg::MAX_POINTS_PER_LANE + 6; k++) begin
            if (k % 8 == 0) vx = k * 4;
            send_vertex(vtx(vx, 0, k == 0, 0, k == nlpp_pkg::MAX_POINTS_PER_LANE + 5));
        end
        wait_drained();
    endtask

    // Receiver holds off while single-vertex sets keep coming, so the input stalls.
    task automatic test_backpressure();
        cur_qx = 0;
        cur_qy = 0;
        rx_hold = 3000;
        for (int k = 0; k < 12; k++) begin
            lane_attrs(k, 0, 0, 0);
            send_vertex(vtx(k, k, 1, 1, 1));
        end
        wait_drained();
    endtask

    // Random sets over several register settings.
    task automatic test_random();
        int unsigned target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(ADDR_MAX_DIST, nlpp_pkg::MAX_DIST_RESET);
                    write_reg(ADDR_MAX_HEAD, nlpp_pkg::MAX_HEAD_RESET);
                end
                1: begin
                    write_reg(ADDR_MAX_DIST, 5000);
                    write_reg(ADDR_MAX_HEAD, nlpp_pkg::PI_Q13);
                end
                2: begin
                    write_reg(ADDR_MAX_DIST, DIST_CAP);
                    write_reg(ADDR_MAX_HEAD, 3000);
                end
                default: begin
                    write_reg(ADDR_MAX_DIST, $urandom_range(0, 100000));
                    write_reg(ADDR_MAX_HEAD, $urandom_range(0, nlpp_pkg::PI_Q13));
                end
            endcase
            target = items_sent + RAND_ITEMS / 4;
            while (items_sent < target) random_set();
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        items_sent = 0;
        rx_hold = 0;
        cycle_count = 0;
        limit_dist = nlpp_pkg::MAX_DIST_RESET;
        limit_head = nlpp_pkg::MAX_HEAD_RESET;
        prev_vx = 0;
        prev_vy = 0;
        seg_cnt = 0;
        arc_acc = 0;
        lane_open = 1'b0;
        lane_has_best = 1'b0;
        lane_best = '0;
        set_has_best = 1'b0;
        set_best = '0;
        lane_attrs(0, 0, 0, 0);
        cur_qx = 0;
        cur_qy = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_directed();
        test_limits();
        test_long_lane();
        test_backpressure();
        test_random();

        wait_drained();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
